// ===== hw/rtl/msvf_pkg.sv =====
// shared types, constants and compare helpers for the memory value scan filter
`timescale 1ns / 1ps

package msvf_pkg;

   localparam int ADDRESS_BITS_DEF = 32;
   localparam int ADDR_W = 32;
   localparam int DATA_W = 64;

   localparam int F32_EXP_BITS  = 8;
   localparam int F32_FRAC_BITS = 23;
   localparam int F64_EXP_BITS  = 11;
   localparam int F64_FRAC_BITS = 52;

   // float adder depth and port-to-port latency
   localparam int FADD_LAT = 5;
   localparam int RSP_LAT  = FADD_LAT + 2;

   // 0.00001 in single precision, and the same value widened to double
   localparam logic [31:0] EPS_F32 = 32'h3727C5AC;
   localparam logic [63:0] EPS_F64 = 64'h3EE4F8B580000000;

   // adder roles
   localparam int ROLES     = 4;
   localparam int ROLE_HI   = 0;
   localparam int ROLE_LO   = 1;
   localparam int ROLE_SUM  = 2;
   localparam int ROLE_DIFF = 3;

   typedef enum logic [3:0] {
      KIND_U8, KIND_S8, KIND_U16, KIND_S16, KIND_U32,
      KIND_S32, KIND_U64, KIND_S64, KIND_F32, KIND_F64
   } kind_type;

   typedef enum logic [3:0] {
      OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE,
      OP_INCREASED, OP_INCREASED_BY, OP_DECREASED, OP_DECREASED_BY,
      OP_CHANGED, OP_CHANGED_BY, OP_UNCHANGED, OP_ANY
   } op_type;

   typedef enum logic [1:0] {
      CSR_VALUE_KIND, CSR_COMPARISON, CSR_TARGET_VALUE
   } csr_index_type;

   typedef struct packed {
      logic in_r;
      logic gt_r;
      logic lt_r;
      logic in_c;
      logic in_d;
   } rel_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] bits;
      kind_type          kind;
      op_type            op;
   } item_type;

   // integer element as an order-preserving unsigned code
   function automatic logic [63:0] norm_int(kind_type k, logic [63:0] v);
      logic [63:0] r;
      unique case (k)
         KIND_U8:  r = {56'b0, v[7:0]};
         KIND_S8:  r = {56'b0, ~v[7], v[6:0]};
         KIND_U16: r = {48'b0, v[15:0]};
         KIND_S16: r = {48'b0, ~v[15], v[14:0]};
         KIND_U32: r = {32'b0, v[31:0]};
         KIND_S32: r = {32'b0, ~v[31], v[30:0]};
         KIND_U64: r = v;
         KIND_S64: r = {~v[63], v[62:0]};
         default:  r = v;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] fp32_key(logic [31:0] x);
      logic [31:0] z;
      z = (x[30:0] == '0) ? '0 : x;
      return z[31] ? ~z : {1'b1, z[30:0]};
   endfunction

   function automatic logic fp32_lt(logic [31:0] a, logic [31:0] b);
      logic nan_a;
      logic nan_b;
      nan_a = (&a[30:23]) && (|a[22:0]);
      nan_b = (&b[30:23]) && (|b[22:0]);
      return !nan_a && !nan_b && (fp32_key(a) < fp32_key(b));
   endfunction

   function automatic logic [63:0] fp64_key(logic [63:0] x);
      logic [63:0] z;
      z = (x[62:0] == '0) ? '0 : x;
      return z[63] ? ~z : {1'b1, z[62:0]};
   endfunction

   function automatic logic fp64_lt(logic [63:0] a, logic [63:0] b);
      logic nan_a;
      logic nan_b;
      nan_a = (&a[62:52]) && (|a[51:0]);
      nan_b = (&b[62:52]) && (|b[51:0]);
      return !nan_a && !nan_b && (fp64_key(a) < fp64_key(b));
   endfunction

endpackage

// ===== hw/rtl/msvf_fadd.sv =====
// five-stage ieee float adder, round to nearest even, no stall
`timescale 1ns / 1ps

module msvf_fadd
   import msvf_pkg::*;
#(
   parameter int EXP_BITS  = F32_EXP_BITS,
   parameter int FRAC_BITS = F32_FRAC_BITS
) (
   input  logic                        clock,
   input  logic [EXP_BITS+FRAC_BITS:0] a,
   input  logic [EXP_BITS+FRAC_BITS:0] b,
   input  logic                        sub,
   output logic [EXP_BITS+FRAC_BITS:0] result
);

   localparam int TW = EXP_BITS + FRAC_BITS + 1;
   localparam int W  = FRAC_BITS + 4;          // significand plus guard, round, sticky
   localparam int DW = $clog2(W + 1);
   localparam int CW = (EXP_BITS + 1 > DW) ? EXP_BITS + 1 : DW;
   localparam logic [EXP_BITS:0] EXP_TOP = (EXP_BITS + 1)'((1 << EXP_BITS) - 1);

   // stage 1: unpack, order by magnitude, align
   logic [EXP_BITS-1:0]  ea, eb, e_big, e_small, ee_big, ee_small, d;
   logic [FRAC_BITS-1:0] f_big, f_small;
   logic                 sb_eff, a_big, s_big, s_small;
   logic                 nan_a, nan_b, inf_a, inf_b;
   logic [FRAC_BITS:0]   m_small;
   logic [DW-1:0]        dcl;
   logic [2*W-1:0]       wide;

   logic [W-1:0]         mb1_in, msh1_in;
   logic                 nan1_in, inf1_in;
   logic [W-1:0]         mb1_ff, msh1_ff;
   logic [EXP_BITS-1:0]  exp1_ff;
   logic                 sub1_ff, sign1_ff, nan1_ff, inf1_ff, isgn1_ff;

   always_comb begin
      ea     = a[TW-2:FRAC_BITS];
      eb     = b[TW-2:FRAC_BITS];
      sb_eff = b[TW-1] ^ sub;
      nan_a  = (&ea) && (|a[FRAC_BITS-1:0]);
      nan_b  = (&eb) && (|b[FRAC_BITS-1:0]);
      inf_a  = (&ea) && !(|a[FRAC_BITS-1:0]);
      inf_b  = (&eb) && !(|b[FRAC_BITS-1:0]);
      nan1_in = nan_a || nan_b || (inf_a && inf_b && (a[TW-1] != sb_eff));
      inf1_in = inf_a || inf_b;

      a_big   = a[TW-2:0] >= b[TW-2:0];
      e_big   = a_big ? ea : eb;
      e_small = a_big ? eb : ea;
      f_big   = a_big ? a[FRAC_BITS-1:0] : b[FRAC_BITS-1:0];
      f_small = a_big ? b[FRAC_BITS-1:0] : a[FRAC_BITS-1:0];
      s_big   = a_big ? a[TW-1] : sb_eff;
      s_small = a_big ? sb_eff : a[TW-1];

      ee_big   = (e_big == '0) ? EXP_BITS'(1) : e_big;
      ee_small = (e_small == '0) ? EXP_BITS'(1) : e_small;
      m_small  = {|e_small, f_small};
      d        = ee_big - ee_small;
      dcl      = (d > EXP_BITS'(W)) ? DW'(W) : DW'(d);
      wide     = {m_small, 3'b000, {W{1'b0}}} >> dcl;

      mb1_in  = {|e_big, f_big, 3'b000};
      msh1_in = {wide[2*W-1:W+1], wide[W] | (|wide[W-1:0])};
   end

   always_ff @(posedge clock) begin
      mb1_ff   <= mb1_in;
      msh1_ff  <= msh1_in;
      exp1_ff  <= ee_big;
      sub1_ff  <= s_big ^ s_small;
      sign1_ff <= s_big;
      nan1_ff  <= nan1_in;
      inf1_ff  <= inf1_in;
      isgn1_ff <= inf_a ? a[TW-1] : sb_eff;
   end

   // stage 2: add or subtract magnitudes
   logic [W:0]          sum2_in;
   logic [W:0]          sum2_ff;
   logic [EXP_BITS-1:0] exp2_ff;
   logic                sign2_ff, nan2_ff, inf2_ff, isgn2_ff;

   assign sum2_in = sub1_ff ? ({1'b0, mb1_ff} - {1'b0, msh1_ff})
                            : ({1'b0, mb1_ff} + {1'b0, msh1_ff});

   always_ff @(posedge clock) begin
      sum2_ff  <= sum2_in;
      exp2_ff  <= exp1_ff;
      sign2_ff <= sign1_ff;
      nan2_ff  <= nan1_ff;
      inf2_ff  <= inf1_ff;
      isgn2_ff <= isgn1_ff;
   end

   // stage 3: carry fold and leading zero count
   logic [W-1:0]        n3_in;
   logic [EXP_BITS:0]   exp3_in, lim;
   logic [DW-1:0]       lzc, sh3_in;
   logic [W-1:0]        n3_ff;
   logic [EXP_BITS:0]   exp3_ff;
   logic [DW-1:0]       sh3_ff;
   logic                sign3_ff, nan3_ff, inf3_ff, isgn3_ff;

   always_comb begin
      n3_in   = sum2_ff[W] ? {sum2_ff[W:2], sum2_ff[1] | sum2_ff[0]} : sum2_ff[W-1:0];
      exp3_in = {1'b0, exp2_ff} + (EXP_BITS + 1)'(sum2_ff[W]);
      lim     = exp3_in - (EXP_BITS + 1)'(1);
      lzc     = DW'(W);
      for (int i = 0; i < W; i++) begin
         if (n3_in[i]) lzc = DW'(W - 1 - i);
      end
      // stop at the subnormal boundary
      sh3_in = (CW'(lzc) > CW'(lim)) ? DW'(lim) : lzc;
   end

   always_ff @(posedge clock) begin
      n3_ff    <= n3_in;
      exp3_ff  <= exp3_in;
      sh3_ff   <= sh3_in;
      sign3_ff <= sign2_ff;
      nan3_ff  <= nan2_ff;
      inf3_ff  <= inf2_ff;
      isgn3_ff <= isgn2_ff;
   end

   // stage 4: normalise
   logic [W-1:0]        n4_in;
   logic [EXP_BITS:0]   e4;
   logic [EXP_BITS-1:0] ef4_in;
   logic [W-1:0]        n4_ff;
   logic [EXP_BITS-1:0] ef4_ff;
   logic                ovf4_ff, sign4_ff, nan4_ff, inf4_ff, isgn4_ff;

   always_comb begin
      n4_in  = n3_ff << sh3_ff;
      e4     = exp3_ff - (EXP_BITS + 1)'(sh3_ff);
      ef4_in = n4_in[W-1] ? e4[EXP_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      n4_ff    <= n4_in;
      ef4_ff   <= ef4_in;
      ovf4_ff  <= n4_in[W-1] && (e4 >= EXP_TOP);
      sign4_ff <= sign3_ff;
      nan4_ff  <= nan3_ff;
      inf4_ff  <= inf3_ff;
      isgn4_ff <= isgn3_ff;
   end

   // stage 5: round and pack, a carry out of the fraction bumps the exponent
   logic                          rup;
   logic [EXP_BITS+FRAC_BITS-1:0] packed5;
   logic [TW-1:0]                 res5_in;
   logic [TW-1:0]                 res5_ff;

   always_comb begin
      rup     = n4_ff[2] && (n4_ff[1] || n4_ff[0] || n4_ff[3]);
      packed5 = {ef4_ff, n4_ff[W-2:3]} + (EXP_BITS + FRAC_BITS)'(rup);
      if (nan4_ff) begin
         res5_in = {1'b0, {EXP_BITS{1'b1}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
      end else if (inf4_ff) begin
         res5_in = {isgn4_ff, {EXP_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
      end else if (ovf4_ff) begin
         res5_in = {sign4_ff, {EXP_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
      end else begin
         res5_in = {sign4_ff, packed5};
      end
   end

   always_ff @(posedge clock) begin
      res5_ff <= res5_in;
   end

   assign result = res5_ff;

endmodule

// ===== hw/rtl/msvf_judge.sv =====
// band compares, mode decode and result register
`timescale 1ns / 1ps

module msvf_judge
   import msvf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  item_type                    in_item,
   input  rel_type                     in_irel,
   input  logic [ROLES-1:0][31:0]      in_f32,
   input  logic [ROLES-1:0][63:0]      in_f64,
   output logic                        out_valid,
   output logic [ADDR_W-1:0]           out_address,
   output logic [DATA_W-1:0]           out_bits
);

   rel_type rel32, rel64, rel_in;
   logic    v6_in;

   always_comb begin
      rel32.in_r = fp32_lt(in_f32[ROLE_LO], in_item.bits[31:0]) &&
                   fp32_lt(in_item.bits[31:0], in_f32[ROLE_HI]);
      rel32.gt_r = fp32_lt(in_f32[ROLE_HI], in_item.bits[31:0]);
      rel32.lt_r = fp32_lt(in_item.bits[31:0], in_f32[ROLE_LO]);
      rel32.in_c = fp32_lt(in_f32[ROLE_LO], in_f32[ROLE_SUM]) &&
                   fp32_lt(in_f32[ROLE_SUM], in_f32[ROLE_HI]);
      rel32.in_d = fp32_lt(in_f32[ROLE_LO], in_f32[ROLE_DIFF]) &&
                   fp32_lt(in_f32[ROLE_DIFF], in_f32[ROLE_HI]);

      rel64.in_r = fp64_lt(in_f64[ROLE_LO], in_item.bits) &&
                   fp64_lt(in_item.bits, in_f64[ROLE_HI]);
      rel64.gt_r = fp64_lt(in_f64[ROLE_HI], in_item.bits);
      rel64.lt_r = fp64_lt(in_item.bits, in_f64[ROLE_LO]);
      rel64.in_c = fp64_lt(in_f64[ROLE_LO], in_f64[ROLE_SUM]) &&
                   fp64_lt(in_f64[ROLE_SUM], in_f64[ROLE_HI]);
      rel64.in_d = fp64_lt(in_f64[ROLE_LO], in_f64[ROLE_DIFF]) &&
                   fp64_lt(in_f64[ROLE_DIFF], in_f64[ROLE_HI]);

      if (in_item.kind == KIND_F32) begin
         rel_in = rel32;
      end else if (in_item.kind == KIND_F64) begin
         rel_in = rel64;
      end else begin
         rel_in = in_irel;
      end
      // unknown element types never match
      v6_in = in_valid && (in_item.kind <= KIND_F64);
   end

   logic              v6_ff;
   logic [ADDR_W-1:0] addr6_ff;
   logic [DATA_W-1:0] bits6_ff;
   op_type            op6_ff;
   rel_type           rel6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      addr6_ff <= in_item.addr;
      bits6_ff <= in_item.bits;
      op6_ff   <= in_item.op;
      rel6_ff  <= rel_in;
   end

   logic hit;

   always_comb begin
      unique case (op6_ff)
         OP_EQ, OP_UNCHANGED:     hit = rel6_ff.in_r;
         OP_NE, OP_CHANGED:       hit = !rel6_ff.in_r;
         OP_GT, OP_INCREASED:     hit = rel6_ff.gt_r;
         OP_GE:                   hit = rel6_ff.in_r || rel6_ff.gt_r;
         OP_LT, OP_DECREASED:     hit = rel6_ff.lt_r;
         OP_LE:                   hit = rel6_ff.in_r || rel6_ff.lt_r;
         OP_INCREASED_BY:         hit = rel6_ff.in_c;
         OP_DECREASED_BY:         hit = rel6_ff.in_d;
         OP_CHANGED_BY:           hit = rel6_ff.in_c || rel6_ff.in_d;
         OP_ANY:                  hit = 1'b1;
         default:                 hit = 1'b0;
      endcase
   end

   logic              out_valid_ff;
   logic [ADDR_W-1:0] out_address_ff;
   logic [DATA_W-1:0] out_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v6_ff && hit;
      end
   end

   always_ff @(posedge clock) begin
      out_address_ff <= addr6_ff;
      out_bits_ff    <= bits6_ff;
   end

   assign out_valid   = out_valid_ff;
   assign out_address = out_address_ff;
   assign out_bits    = out_bits_ff;

   a_bad_kind_drops: assert property (@(posedge clock) disable iff (reset)
      (in_valid && (in_item.kind > KIND_F64)) |-> ##2 !out_valid)
      else $error("item with unknown element type produced a result");

   a_any_matches: assert property (@(posedge clock) disable iff (reset)
      (in_valid && (in_item.kind <= KIND_F64) && (in_item.op == OP_ANY)) |-> ##2 out_valid)
      else $error("match-all item produced no result");

endmodule

// ===== hw/rtl/memory_value_scan_filter.sv =====
// memory value scan filter: config registers, operand select, float adders, delay line
// a result strobes on rsp_valid once its item has passed the float adder stages and the judge registers
// throughput: one item per cycle outside reset, through the five-stage float adders and two compare stages
// reset: synchronous; clears pipeline valid bits, value_kind to u32, comparison to eq,
// target_value to 0; busy is high and csr_ready is low only while reset is high
// the receiver cannot stall, so the pipeline never holds
`timescale 1ns / 1ps

module memory_value_scan_filter
   import msvf_pkg::*;
#(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ADDR_W-1:0] req_word_address,
   input  logic              req_address_ok,
   input  logic [DATA_W-1:0] req_read_bits,
   input  logic [DATA_W-1:0] req_prior_bits,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [DATA_W-1:0] csr_data,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_match_address,
   output logic [DATA_W-1:0] rsp_match_bits
);

   localparam int KEEP_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
   localparam logic [ADDR_W:0]   ADDR_LIMIT = (ADDR_W + 1)'(1) << KEEP_BITS;
   localparam logic [ADDR_W-1:0] ADDR_MASK  = ADDR_W'(ADDR_LIMIT - (ADDR_W + 1)'(1));

   assign busy      = reset;
   assign csr_ready = !reset;

   // configuration registers
   kind_type          kind_ff, kind_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] target_ff, target_in;

   always_comb begin
      kind_in   = kind_ff;
      op_in     = op_ff;
      target_in = target_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_VALUE_KIND) begin
            kind_in = kind_type'(csr_data[3:0]);
         end else if (csr_index == CSR_COMPARISON) begin
            op_in = op_type'(csr_data[3:0]);
         end else if (csr_index == CSR_TARGET_VALUE) begin
            target_in = csr_data;
         end
      end
   end

   // reference operand for the band: target, prior, or read for the delta modes
   logic [DATA_W-1:0] s_sel;

   always_comb begin
      unique case (op_ff)
         OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE:
            s_sel = target_ff;
         OP_INCREASED_BY, OP_DECREASED_BY, OP_CHANGED_BY:
            s_sel = req_read_bits;
         default:
            s_sel = req_prior_bits;
      endcase
   end

   // item delay line alongside the adders
   logic     vld_in;
   item_type pipe_in;
   logic [FADD_LAT-1:0] vld_ff;
   item_type pipe_ff [FADD_LAT];

   always_comb begin
      vld_in       = start && !busy && req_address_ok;
      pipe_in.addr = req_word_address & ADDR_MASK;
      pipe_in.bits = req_read_bits;
      pipe_in.kind = kind_ff;
      pipe_in.op   = op_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         kind_ff   <= KIND_U32;
         op_ff     <= OP_EQ;
         target_ff <= '0;
      end else begin
         vld_ff    <= {vld_ff[FADD_LAT-2:0], vld_in};
         kind_ff   <= kind_in;
         op_ff     <= op_in;
         target_ff <= target_in;
      end
   end

   // integer path: normalised operands, then compares, then delay
   logic [DATA_W-1:0] nr_ff, ns_ff, nc_ff, nd_ff;
   rel_type           irel_in;
   rel_type           irel_ff [1:FADD_LAT-1];

   always_comb begin
      irel_in.in_r = nr_ff == ns_ff;
      irel_in.gt_r = nr_ff > ns_ff;
      irel_in.lt_r = nr_ff < ns_ff;
      irel_in.in_c = nr_ff == nc_ff;
      irel_in.in_d = nr_ff == nd_ff;
   end

   always_ff @(posedge clock) begin
      pipe_ff[0] <= pipe_in;
      for (int i = 1; i < FADD_LAT; i++) begin
         pipe_ff[i] <= pipe_ff[i-1];
      end
      nr_ff <= norm_int(kind_ff, req_read_bits);
      ns_ff <= norm_int(kind_ff, s_sel);
      nc_ff <= norm_int(kind_ff, target_ff + req_prior_bits);
      nd_ff <= norm_int(kind_ff, req_prior_bits - target_ff);
      irel_ff[1] <= irel_in;
      for (int i = 2; i < FADD_LAT; i++) begin
         irel_ff[i] <= irel_ff[i-1];
      end
   end

   // float adders: band edges s +/- eps, then target + prior and prior - target
   logic [DATA_W-1:0]         op_a [ROLES];
   logic [DATA_W-1:0]         op_b [ROLES];
   logic [ROLES-1:0][31:0]    res32;
   logic [ROLES-1:0][63:0]    res64;

   always_comb begin
      op_a[ROLE_HI]   = s_sel;
      op_b[ROLE_HI]   = EPS_F64;
      op_a[ROLE_LO]   = s_sel;
      op_b[ROLE_LO]   = EPS_F64;
      op_a[ROLE_SUM]  = target_ff;
      op_b[ROLE_SUM]  = req_prior_bits;
      op_a[ROLE_DIFF] = req_prior_bits;
      op_b[ROLE_DIFF] = target_ff;
   end

   for (genvar g = 0; g < ROLES; g++) begin : g_role
      localparam logic IS_SUB = (g == ROLE_LO) || (g == ROLE_DIFF);
      localparam logic IS_EPS = (g == ROLE_HI) || (g == ROLE_LO);

      msvf_fadd #(
         .EXP_BITS  (F32_EXP_BITS),
         .FRAC_BITS (F32_FRAC_BITS)
      ) u_f32 (
         .clock  (clock),
         .a      (op_a[g][31:0]),
         .b      (IS_EPS ? EPS_F32 : op_b[g][31:0]),
         .sub    (IS_SUB),
         .result (res32[g])
      );

      msvf_fadd #(
         .EXP_BITS  (F64_EXP_BITS),
         .FRAC_BITS (F64_FRAC_BITS)
      ) u_f64 (
         .clock  (clock),
         .a      (op_a[g]),
         .b      (op_b[g]),
         .sub    (IS_SUB),
         .result (res64[g])
      );
   end

   msvf_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld_ff[FADD_LAT-1]),
      .in_item     (pipe_ff[FADD_LAT-1]),
      .in_irel     (irel_ff[FADD_LAT-1]),
      .in_f32      (res32),
      .in_f64      (res64),
      .out_valid   (rsp_valid),
      .out_address (rsp_match_address),
      .out_bits    (rsp_match_bits)
   );

   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_address_ok, RSP_LAT))
      else $error("result without a valid item accepted at the right time");

   a_rsp_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_bits == $past(req_read_bits, RSP_LAT)))
      else $error("result bits do not follow the accepted item");

   a_rsp_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_address == ($past(req_word_address, RSP_LAT) & ADDR_MASK)))
      else $error("result address does not follow the accepted item");

endmodule

// ===== test/scan_match_checker.sv =====
// float helpers and the result checker for the memory value scan filter
`timescale 1ns / 1ps

package scan_float_pkg;

   // single-precision bits widened exactly to a real
   function automatic real f32_to_real(logic [31:0] x);
      logic [63:0] d;
      logic [22:0] f;
      int k;
      f = x[22:0];
      k = 0;
      if (x[30:23] == 8'hff) begin
         d = {x[31], 11'h7ff, f, 29'b0};
      end else if (x[30:23] == 8'h00) begin
         if (f == '0) begin
            d = {x[31], 63'b0};
         end else begin
            // subnormal: normalise so the leading one sits at bit 22
            while (!f[22]) begin
               f = f << 1;
               k++;
            end
            d = {x[31], 11'(896 - k), f[21:0], 30'b0};
         end
      end else begin
         d = {x[31], 11'(x[30:23]) + 11'd896, f, 29'b0};
      end
      return $bitstoreal(d);
   endfunction

   // real rounded to nearest-even single precision
   function automatic logic [31:0] real_to_f32(real v);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] rem;
      logic [63:0] half;
      logic s;
      int fe;
      int sh;
      d = $realtobits(v);
      s = d[63];
      if (d[62:52] == 11'h7ff) return {s, 8'hff, (d[51:0] != '0) ? 23'h400000 : 23'h0};
      if (d[62:52] == 11'h000) return {s, 31'b0};
      fe = int'(d[62:52]) - 896;
      if (fe >= 255) return {s, 8'hff, 23'b0};
      sig = {11'b0, 1'b1, d[51:0]};
      sh = (fe >= 1) ? 29 : 30 - fe;
      if (sh > 60) return {s, 31'b0};
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      sig = sig >> sh;
      if (rem > half || (rem == half && sig[0])) sig = sig + 64'd1;
      if (fe >= 1) begin
         if (sig[24]) begin
            sig = sig >> 1;
            fe++;
         end
         if (fe >= 255) return {s, 8'hff, 23'b0};
         return {s, 8'(fe), sig[22:0]};
      end
      // a carry out of the subnormal range lands on the smallest normal
      return {s, sig[30:0]};
   endfunction

endpackage

module scan_match_checker
   import msvf_pkg::*;
   import scan_float_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [ADDR_W-1:0] req_word_address,
   input  logic              req_address_ok,
   input  logic [DATA_W-1:0] req_read_bits,
   input  logic [DATA_W-1:0] req_prior_bits,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [DATA_W-1:0] csr_data,
   input  logic              rsp_valid,
   input  logic [ADDR_W-1:0] rsp_match_address,
   input  logic [DATA_W-1:0] rsp_match_bits,
   output int                mismatch_count,
   output int                outstanding,
   output int                matches_seen
);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] bits;
   } match_type;

   match_type   matches_due[$];
   logic [3:0]  elem_kind;
   logic [3:0]  compare_mode;
   logic [63:0] search_bits;

   function automatic logic [63:0] elem_mask(logic [3:0] kind);
      case (kind)
         KIND_U8, KIND_S8:   return 64'hff;
         KIND_U16, KIND_S16: return 64'hffff;
         KIND_U32, KIND_S32: return 64'hffff_ffff;
         default:            return '1;
      endcase
   endfunction

   // r judged against reference s
   function automatic bit elem_test(logic [3:0] kind, op_type op, logic [63:0] s,
                                    logic [63:0] r);
      real sv;
      real rv;
      real top;
      real bot;
      logic [63:0] m;
      logic [63:0] ns;
      logic [63:0] nr;
      bit inband;
      if (kind == KIND_F32 || kind == KIND_F64) begin
         if (kind == KIND_F32) begin
            sv  = f32_to_real(s[31:0]);
            rv  = f32_to_real(r[31:0]);
            top = f32_to_real(real_to_f32(sv + f32_to_real(EPS_F32)));
            bot = f32_to_real(real_to_f32(sv - f32_to_real(EPS_F32)));
         end else begin
            sv  = $bitstoreal(s);
            rv  = $bitstoreal(r);
            top = sv + $bitstoreal(EPS_F64);
            bot = sv - $bitstoreal(EPS_F64);
         end
         inband = (bot < rv) && (rv < top);
         case (op)
            OP_EQ:   return inband;
            OP_NE:   return !inband;
            OP_GT:   return rv > top;
            OP_GE:   return inband || (rv > top);
            OP_LT:   return rv < bot;
            OP_LE:   return inband || (rv < bot);
            default: return 1'b0;
         endcase
      end
      m  = elem_mask(kind);
      ns = s & m;
      nr = r & m;
      if (kind[0]) begin
         // flip the sign bit so signed order becomes unsigned order
         ns = ns ^ (m ^ (m >> 1));
         nr = nr ^ (m ^ (m >> 1));
      end
      case (op)
         OP_EQ:   return nr == ns;
         OP_NE:   return nr != ns;
         OP_GT:   return nr > ns;
         OP_GE:   return nr >= ns;
         OP_LT:   return nr < ns;
         OP_LE:   return nr <= ns;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [63:0] elem_sum(logic [3:0] kind, logic [63:0] a,
                                            logic [63:0] b, bit sub);
      real x;
      real y;
      if (kind == KIND_F32) begin
         x = f32_to_real(a[31:0]);
         y = f32_to_real(b[31:0]);
         return {32'b0, real_to_f32(sub ? x - y : x + y)};
      end
      if (kind == KIND_F64) begin
         x = $bitstoreal(a);
         y = $bitstoreal(b);
         return $realtobits(sub ? x - y : x + y);
      end
      return sub ? a - b : a + b;
   endfunction

   function automatic bit word_matches(logic [63:0] r, logic [63:0] p);
      if (elem_kind > KIND_F64) return 1'b0;
      case (compare_mode)
         OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE:
            return elem_test(elem_kind, op_type'(compare_mode), search_bits, r);
         OP_INCREASED:    return elem_test(elem_kind, OP_GT, p, r);
         OP_INCREASED_BY:
            return elem_test(elem_kind, OP_EQ, r, elem_sum(elem_kind, search_bits, p, 0));
         OP_DECREASED:    return elem_test(elem_kind, OP_LT, p, r);
         OP_DECREASED_BY:
            return elem_test(elem_kind, OP_EQ, r, elem_sum(elem_kind, p, search_bits, 1));
         OP_CHANGED:      return elem_test(elem_kind, OP_NE, p, r);
         OP_CHANGED_BY:
            return elem_test(elem_kind, OP_EQ, r, elem_sum(elem_kind, search_bits, p, 0))
                || elem_test(elem_kind, OP_EQ, r, elem_sum(elem_kind, p, search_bits, 1));
         OP_UNCHANGED:    return elem_test(elem_kind, OP_EQ, p, r);
         OP_ANY:          return 1'b1;
         default:         return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      match_type got;
      match_type want;
      match_type next_due;
      if (reset) begin
         elem_kind      = KIND_U32;
         compare_mode   = OP_EQ;
         search_bits    = '0;
         mismatch_count = 0;
         matches_seen   = 0;
         matches_due.delete();
      end else begin
         if (rsp_valid) begin
            got = '{rsp_match_address, rsp_match_bits};
            matches_seen++;
            if (matches_due.size() == 0) begin
               $display("%0t: unexpected match addr %h bits %h", $time, got.addr, got.bits);
               mismatch_count++;
            end else begin
               want = matches_due.pop_front();
               if (got.addr !== want.addr) begin
                  $display("%0t: match_address expected %h actual %h",
                           $time, want.addr, got.addr);
                  mismatch_count++;
               end
               if (got.bits !== want.bits) begin
                  $display("%0t: match_bits expected %h actual %h",
                           $time, want.bits, got.bits);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy && req_address_ok
             && word_matches(req_read_bits, req_prior_bits)) begin
            next_due    = '{req_word_address, req_read_bits};
            matches_due = {matches_due, next_due};
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VALUE_KIND:   elem_kind    = csr_data[3:0];
               CSR_COMPARISON:   compare_mode = csr_data[3:0];
               CSR_TARGET_VALUE: search_bits  = csr_data;
               default: ;
            endcase
         end
      end
      outstanding = matches_due.size();
   end

endmodule

// ===== test/testbench.sv =====
// stimulus and verdict for the memory value scan filter
`timescale 1ns / 1ps

module testbench;
   import msvf_pkg::*;
   import scan_float_pkg::*;

   localparam int         IDLE_LIMIT = 2000;
   localparam logic [3:0] BAD_KIND   = 4'd12;
   localparam logic [3:0] BAD_OP     = 4'd15;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [ADDR_W-1:0] req_word_address;
   logic              req_address_ok;
   logic [DATA_W-1:0] req_read_bits;
   logic [DATA_W-1:0] req_prior_bits;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [DATA_W-1:0] csr_data;
   logic              rsp_valid;
   logic [ADDR_W-1:0] rsp_match_address;
   logic [DATA_W-1:0] rsp_match_bits;
   int                mismatch_count;
   int                outstanding;
   int                matches_seen;
   int                idle_cycles = 0;
   int                items_sent = 0;
   int                idle_pct = 0;

   always #1 clock = ~clock;

   memory_value_scan_filter u_top (.*);

   scan_match_checker u_checker (.*);

   always @(posedge clock) begin
      if ((start && !busy) || (csr_valid && csr_ready) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_word(logic [31:0] addr, logic ok, logic [63:0] rd, logic [63:0] pr);
      // sender idles in roughly idle_pct cycles of a hundred
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_word_address <= addr;
      req_address_ok   <= ok;
      req_read_bits    <= rd;
      req_prior_bits   <= pr;
      do @(negedge clock); while (busy);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
   endtask

   // drain, let dropped items clear the pipe, then reprogram
   task automatic set_mode(logic [3:0] kind, logic [3:0] op, logic [63:0] target);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (RSP_LAT + 2) @(posedge clock);
      write_reg(CSR_VALUE_KIND, {60'b0, kind});
      write_reg(CSR_COMPARISON, {60'b0, op});
      write_reg(CSR_TARGET_VALUE, target);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] width_mask(logic [3:0] kind);
      case (kind)
         KIND_U8, KIND_S8:             return 64'hff;
         KIND_U16, KIND_S16:           return 64'hffff;
         KIND_U32, KIND_S32, KIND_F32: return 64'hffff_ffff;
         default:                      return '1;
      endcase
   endfunction

   function automatic real nice_real();
      return real'(int'($urandom_range(0, 16384)) - 8192) / 8.0;
   endfunction

   function automatic logic [63:0] pick_value(logic [3:0] kind);
      logic [63:0] v;
      logic [63:0] m;
      int sel;
      m   = width_mask(kind);
      sel = $urandom_range(9);
      v   = {$urandom, $urandom};
      if (sel < 2) begin
         // edge values: zeros, infinities, nan, subnormal, sign boundaries
         case ($urandom_range(6))
            0: v = '0;
            1: v = (kind == KIND_F64) ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
            2: v = (kind == KIND_F64) ? 64'h7ff0_0000_0000_0000 : 64'h7f80_0000;
            3: v = (kind == KIND_F64) ? 64'h7ff8_0000_0000_0001 : 64'h7fc0_0001;
            4: v = 64'd1;
            5: v = m;
            default: v = (m ^ (m >> 1)) - ($urandom_range(1) ? 64'd1 : 64'd0);
         endcase
      end else if (kind == KIND_F32) begin
         v = {32'b0, real_to_f32(nice_real())};
      end else if (kind == KIND_F64) begin
         v = $realtobits(nice_real());
      end else if (sel < 7) begin
         v = 64'(int'($urandom_range(0, 400)) - 200);
      end
      // bits above the element are sometimes noise
      if ($urandom_range(1)) v = (v & m) | ({$urandom, $urandom} & ~m);
      return v;
   endfunction

   function automatic logic [63:0] value_sum(logic [3:0] kind, logic [63:0] a,
                                             logic [63:0] b, bit sub);
      if (kind == KIND_F32)
         return {$urandom, real_to_f32(sub ? f32_to_real(a[31:0]) - f32_to_real(b[31:0])
                                           : f32_to_real(a[31:0]) + f32_to_real(b[31:0]))};
      if (kind == KIND_F64)
         return $realtobits(sub ? $bitstoreal(a) - $bitstoreal(b)
                                : $bitstoreal(a) + $bitstoreal(b));
      return sub ? a - b : a + b;
   endfunction

   function automatic logic [63:0] nudge(logic [63:0] v);
      if ($urandom_range(1)) return v + 64'(int'($urandom_range(0, 6)) - 3);
      return v + 64'(int'($urandom_range(0, 4000)) - 2000);
   endfunction

   initial begin
      logic [3:0]  kind;
      logic [3:0]  op;
      logic [63:0] target;
      logic [63:0] prior;
      logic [63:0] rd;
      start            <= 1'b0;
      req_word_address <= '0;
      req_address_ok   <= 1'b0;
      req_read_bits    <= '0;
      req_prior_bits   <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;
      reset            <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: u32 equal to zero, high bits ignored
      send_word(32'h0, 1'b1, 64'hffff_ffff_0000_0000, 64'h0);
      send_word(32'hffff_ffff, 1'b1, 64'h0, {$urandom, $urandom});
      send_word(32'h1234_5678, 1'b0, 64'h0, 64'h0);
      send_word(32'h1, 1'b1, 64'h1, 64'h0);
      set_mode(KIND_S8, OP_LT, 64'h7f);
      send_word(32'h10, 1'b1, 64'h80, 64'h0);
      send_word(32'h11, 1'b1, 64'h7f, 64'h0);
      send_word(32'h12, 1'b1, 64'hff, 64'h0);
      set_mode(KIND_F32, OP_EQ, 64'h3f80_0000);
      send_word(32'h20, 1'b1, 64'h7fc0_0000, 64'h0);
      send_word(32'h21, 1'b1, 64'hdead_beef_3f80_0000, 64'h0);
      send_word(32'h22, 1'b1, 64'h3f80_0001, 64'h0);
      send_word(32'h23, 1'b1, 64'h3f80_0100, 64'h0);
      set_mode(KIND_F32, OP_NE, 64'h3f80_0000);
      send_word(32'h24, 1'b1, 64'h7fc0_0000, 64'h0);
      set_mode(KIND_F64, OP_CHANGED_BY, 64'h4000_0000_0000_0000);
      send_word(32'h30, 1'b1, 64'h4008_0000_0000_0000, 64'h3ff0_0000_0000_0000);
      send_word(32'h31, 1'b1, 64'hbff0_0000_0000_0000, 64'h3ff0_0000_0000_0000);
      send_word(32'h32, 1'b1, 64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000);
      set_mode(BAD_KIND, OP_ANY, 64'h0);
      send_word(32'h40, 1'b1, 64'h0, 64'h0);
      set_mode(KIND_U64, BAD_OP, '1);
      send_word(32'h41, 1'b1, '1, 64'h0);
      set_mode(KIND_U64, OP_ANY, '1);
      send_word(32'h42, 1'b1, '1, 64'h0);

      for (int ph = 0; ph < 44; ph++) begin
         idle_pct = (ph < 15) ? 10 : (ph < 30) ? 82 : 0;
         kind = (ph % 11 == 10) ? 4'($urandom_range(10, 15)) : 4'(ph % 11);
         op   = 4'(ph % 16);
         target = (ph == 0) ? 64'h0 : (ph == 1) ? '1 : pick_value(kind);
         set_mode(kind, op, target);
         for (int i = 0; i < 26; i++) begin
            prior = pick_value(kind);
            case ($urandom_range(9))
               0:       rd = target;
               1:       rd = nudge(target);
               2, 3:    rd = prior;
               4:       rd = value_sum(kind, prior, target, 0);
               5:       rd = value_sum(kind, prior, target, 1);
               6, 7:    rd = nudge(prior);
               default: rd = pick_value(kind);
            endcase
            send_word($urandom, $urandom_range(9) != 0, rd, prior);
            if (ph == 20 && i == 13) begin
               // hold off until the pipe has delivered everything
               start <= 1'b0;
               do @(posedge clock); while (outstanding != 0);
            end
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (RSP_LAT + 4) @(posedge clock);
      $display("run covered %0d words over 52 settings of element type and comparison",
               items_sent);
      $display("%0d matches checked, %0d still awaited", matches_seen, outstanding);
      if (mismatch_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
